@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define LSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define LSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define LSB_ASSERT(lbl, clk, rstn, prop)
`define LSB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hw/rtl/lsb_pkg.sv @@
// ----------------------------------------------------------------------------
// lsb_pkg
// Types, widths and constants shared by the LSB stego embedder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsb_pkg;

  localparam int unsigned PREFIX_BYTES_DEF = 8;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CHUNK_W    = 36;
  localparam int unsigned HDR_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_COVER   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_MODE  = 1'd0,
    CFG_FILE_LENGTH = 1'd1
  } cfg_idx_t;

  localparam logic [HDR_W-1:0] HDR_DONE = 2'd2;

  function automatic logic [BYTE_W-1:0] chunk_mask(input logic [MODE_W-1:0] mode);
    logic [BYTE_W-1:0] m;
    unique case (mode)
      2'd0:    m = 8'b00000001;
      2'd1:    m = 8'b00000011;
      2'd2:    m = 8'b00001111;
      default: m = 8'b11111111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lsb_in_if.sv @@
// ----------------------------------------------------------------------------
// lsb_in_if
// Input channel: operation and value with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsb_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsb_pkg::OP_W-1:0]     operation;
  logic [lsb_pkg::BYTE_W-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lsb_out_if.sv @@
// ----------------------------------------------------------------------------
// lsb_out_if
// Result channel: stego byte and status flags with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsb_out_if;
  logic                         valid;
  logic                         ready;
  logic [lsb_pkg::BYTE_W-1:0]   stego_byte;
  logic                         payload_underrun;
  logic                         embedding_done;

  modport source (output valid, output stego_byte, output payload_underrun,
                  output embedding_done, input ready);
  modport sink   (input valid, input stego_byte, input payload_underrun,
                  input embedding_done, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lsb_stego_embedder.sv @@
// ----------------------------------------------------------------------------
// lsb_stego_embedder
// Replaces the low bits of cover bytes with mode bits, a length prefix and
// payload chunks of 1, 2, 4 or 8 bits.
//
//   channel  dir  signals                                     transfer when
//   in_ch    in   operation, value                            valid & ready
//   out_ch   out  stego_byte, payload_underrun, embedding_done valid & ready
//   cfg      in   cfg_we, cfg_index, cfg_wdata                 cfg_we
//
// One item per cycle while in_ch.ready is high; a cover byte's result is
// registered in the cycle after its transfer. Embedding position comes
// from the chunk counter through a shift, a mask and a 36-bit compare
// against the chunk total. Load, restart and unused operations give no
// result. in_ch.ready drops only while a result is held and out_ch.ready
// is low. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lsb_stego_embedder #(
  parameter int unsigned PREFIX_BYTES = lsb_pkg::PREFIX_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  lsb_in_if.sink                                in_ch,
  lsb_out_if.source                             out_ch
);

  localparam int unsigned CW = lsb_pkg::CHUNK_W;
  localparam int unsigned BW = lsb_pkg::BYTE_W;

  logic [lsb_pkg::MODE_W-1:0] mode_r;
  logic [lsb_pkg::LEN_W-1:0]  file_length_r;

  logic [lsb_pkg::HDR_W-1:0]  header_count_r, header_count_nxt;
  logic [CW-1:0]              chunk_count_r, chunk_count_nxt;
  logic [BW-1:0]              held_payload_r, held_payload_nxt;
  logic                       held_valid_r, held_valid_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [BW-1:0]              stego_r, stego_nxt;
  logic                       underrun_r, underrun_nxt;
  logic                       done_r, done_nxt;

  logic                       in_xfer;
  logic [1:0]                 per_shift;
  logic [3:0]                 per_byte;
  logic [2:0]                 pos_mask;
  logic [2:0]                 pos;
  logic [CW-1:0]              byte_index;
  logic [CW-1:0]              total;
  logic [BW-1:0]              size_mask;
  logic [3:0]                 shift;
  logic                       is_payload;
  logic [BW-1:0]              src;
  logic [BW-1:0]              chunk;
  logic                       last;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.stego_byte       = stego_r;
  assign out_ch.payload_underrun = underrun_r;
  assign out_ch.embedding_done   = done_r;

  always_comb begin
    per_shift  = 2'd3 - mode_r;
    per_byte   = 4'd8 >> mode_r;
    pos_mask   = 3'(per_byte - 4'd1);
    pos        = chunk_count_r[2:0] & pos_mask;
    byte_index = chunk_count_r >> per_shift;
    total      = (CW'(PREFIX_BYTES) + CW'(file_length_r)) << per_shift;
    size_mask  = lsb_pkg::chunk_mask(mode_r);
    shift      = 4'd8 - ((4'(pos) + 4'd1) << mode_r);
    is_payload = byte_index >= CW'(PREFIX_BYTES);
    last       = (pos == pos_mask);
    if (is_payload) begin
      src = held_payload_r;
    end else if (byte_index < CW'(4)) begin
      src = file_length_r[8*byte_index[1:0] +: 8];
    end else begin
      src = '0;
    end
    chunk = (src >> shift[2:0]) & size_mask;
  end

  always_comb begin
    header_count_nxt = header_count_r;
    chunk_count_nxt  = chunk_count_r;
    held_payload_nxt = held_payload_r;
    held_valid_nxt   = held_valid_r;
    stego_nxt        = stego_r;
    underrun_nxt     = underrun_r;
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;

    if (in_xfer) begin
      unique case (lsb_pkg::op_t'(in_ch.operation))
        lsb_pkg::OP_LOAD: begin
          held_payload_nxt = in_ch.value;
          held_valid_nxt   = 1'b1;
        end
        lsb_pkg::OP_RESTART: begin
          header_count_nxt = '0;
          chunk_count_nxt  = '0;
          held_payload_nxt = '0;
          held_valid_nxt   = 1'b0;
        end
        lsb_pkg::OP_COVER: begin
          out_valid_nxt = 1'b1;
          stego_nxt     = in_ch.value;
          underrun_nxt  = 1'b0;
          if (header_count_r < lsb_pkg::HDR_DONE) begin
            stego_nxt        = {in_ch.value[BW-1:1], mode_r[header_count_r[0]]};
            header_count_nxt = header_count_r + 2'd1;
          end else if (chunk_count_r < total) begin
            if (is_payload && !held_valid_r) begin
              underrun_nxt = 1'b1;
            end else begin
              stego_nxt       = (in_ch.value & ~size_mask) | chunk;
              chunk_count_nxt = chunk_count_r + CW'(1);
              if (last && is_payload) begin
                held_valid_nxt = 1'b0;
              end
            end
          end
          done_nxt = (header_count_nxt == lsb_pkg::HDR_DONE) && (chunk_count_nxt >= total);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= '0;
      file_length_r  <= '0;
      header_count_r <= '0;
      chunk_count_r  <= '0;
      held_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      header_count_r <= header_count_nxt;
      chunk_count_r  <= chunk_count_nxt;
      held_valid_r   <= held_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (lsb_pkg::cfg_idx_t'(cfg_index))
          lsb_pkg::CFG_CHUNK_MODE:  mode_r        <= cfg_wdata[lsb_pkg::MODE_W-1:0];
          lsb_pkg::CFG_FILE_LENGTH: mode_r        <= mode_r;
          default:                  mode_r        <= mode_r;
        endcase
        if (lsb_pkg::cfg_idx_t'(cfg_index) == lsb_pkg::CFG_FILE_LENGTH) begin
          file_length_r <= cfg_wdata[lsb_pkg::LEN_W-1:0];
        end
      end
    end
    held_payload_r <= held_payload_nxt;
    stego_r        <= stego_nxt;
    underrun_r     <= underrun_nxt;
    done_r         <= done_nxt;
  end

  `LSB_ASSERT(a_hdr_range, clk, rst_n, header_count_r <= lsb_pkg::HDR_DONE)
  `LSB_ASSERT(a_no_chunk_in_hdr, clk, rst_n, (header_count_r < lsb_pkg::HDR_DONE) |-> (chunk_count_r == '0))
  `LSB_ASSERT(a_underrun_not_done, clk, rst_n, (out_valid_r && underrun_r) |-> !done_r)
  `LSB_ASSERT(a_restart_clears, clk, rst_n, (in_xfer && in_ch.operation == lsb_pkg::OP_RESTART) |=> (chunk_count_r == '0 && header_count_r == '0 && !held_valid_r))
  `LSB_ASSERT(a_chunk_step, clk, rst_n, (chunk_count_r != $past(chunk_count_r)) |-> (chunk_count_r == '0 || chunk_count_r == $past(chunk_count_r) + CW'(1)))

endmodule

`default_nettype wire
